// File: sv/gtm_pkg.sv
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared types, codes and constants of the greedy triangle matcher.
// ----------------------------------------------------------------------------
package gtm_pkg;

  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int COORD_W = 16;
  localparam int VERTEX_W = 4 * COORD_W;
  localparam int VDIST_W = 17;
  localparam int TDIST_W = 19;

  localparam logic [2:0] KIND_LOAD_REF  = 3'd0;
  localparam logic [2:0] KIND_LOAD_CAND = 3'd1;
  localparam logic [2:0] KIND_RUN       = 3'd2;
  localparam logic [2:0] KIND_READ      = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SLOT  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0]          kind;
    logic signed [15:0]  coord_x;
    logic signed [15:0]  coord_y;
    logic signed [15:0]  coord_z;
    logic signed [15:0]  coord_w;
    logic [7:0]          slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  source_triangle;
    logic [18:0] match_distance;
    logic [8:0]  triangle_count;
  } rsp_t;

  typedef enum logic [3:0] {
    RS_IDLE,
    RS_SCAN_START,
    RS_SCAN_RD,
    RS_SCAN_WAIT,
    RS_SCAN_DIST,
    RS_SCAN_NEXT,
    RS_SWAP_A,
    RS_SWAP_B,
    RS_SWAP_C,
    RS_SWAP_D,
    RS_DONE
  } run_state_t;

  typedef enum logic [1:0] {
    VD_IDLE,
    VD_SQUARE,
    VD_ROOT,
    VD_DONE
  } vd_state_t;

endpackage

// File: sv/gtm_ram.sv
// ----------------------------------------------------------------------------
// gtm_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gtm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/gtm_vdist.sv
// ----------------------------------------------------------------------------
// gtm_vdist
// Vertex distance unit: squares the four lane differences one per cycle, then
// takes the floor square root one result bit per cycle.
// ----------------------------------------------------------------------------
module gtm_vdist
  import gtm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [VERTEX_W-1:0] vert_a,
  input  logic [VERTEX_W-1:0] vert_b,
  output logic                done,
  output logic [VDIST_W-1:0]  root
);

  vd_state_t           state, state_next;
  logic [VERTEX_W-1:0] va, vb;
  logic [33:0]         acc;
  logic [33:0]         res;
  logic [1:0]          k;
  logic [4:0]          step;
  logic signed [16:0]  diff;
  logic [16:0]         mag;
  logic [31:0]         sq;
  logic [33:0]         bitv;
  logic [34:0]         trial;
  logic                take;

  always_comb begin
    diff  = 17'(signed'(va[16*k +: 16])) - 17'(signed'(vb[16*k +: 16]));
    mag   = diff[16] ? 17'(-diff) : 17'(diff);
    sq    = mag[15:0] * mag[15:0];
    bitv  = 34'(1) << {step, 1'b0};
    trial = {1'b0, res} + {1'b0, bitv};
    take  = {1'b0, acc} >= trial;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      VD_IDLE:   if (start) state_next = VD_SQUARE;
      VD_SQUARE: if (k == 2'd3) state_next = VD_ROOT;
      VD_ROOT:   if (step == 5'd0) state_next = VD_DONE;
      VD_DONE:   state_next = VD_IDLE;
      default:   state_next = VD_IDLE;
    endcase
  end

  always_comb begin
    done = (state == VD_DONE);
    root = res[VDIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= VD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      VD_IDLE: begin
        if (start) begin
          va  <= vert_a;
          vb  <= vert_b;
          acc <= '0;
          k   <= '0;
        end
      end
      VD_SQUARE: begin
        acc <= acc + 34'(sq);
        k   <= k + 2'd1;
        step <= 5'd16;
        res  <= '0;
      end
      VD_ROOT: begin
        if (take) begin
          acc <= acc - trial[33:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        step <= step - 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/greedy_triangle_match_reorder.sv
// ----------------------------------------------------------------------------
// greedy_triangle_match_reorder
// Greedy nearest-triangle matcher that reorders a candidate mesh against a
// reference mesh held in on-chip RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), one beat per command: vertex loads,
// run, slot read and clear. Responses leave on rsp (valid/ready), one beat
// for each run and each slot read; loads and clear give none.
// Vertex loads and clear are accepted every cycle while req_ready is high.
// A slot read is accepted on the same terms; its response beat comes from the
// RAM read register and the pending flag, both loaded at acceptance, and then
// from the response register, which loads once the output is free.
// A run walks the stores: for each reference triangle it sets up a scan, then
// for each remaining candidate triangle it handles the three vertex pairs in
// turn (read, hand-over, squaring of the four lanes, the root one result bit
// at a time and the result) and compares the sum, then swaps the best
// candidate into place; a response beat ends the run. An invalid or empty run
// goes straight to its response. No request is taken during a run.
// Reset empties both meshes, clears the error flag and the matched count;
// the RAM contents stay undefined until loaded.
// When the receiver stalls, one response waits in the output register and
// at most one slot read waits behind it; then req_ready drops.
// ----------------------------------------------------------------------------
module greedy_triangle_match_reorder
  import gtm_pkg::*;
#(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int TI_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int TC_W = $clog2(MAX_TRIANGLES + 1);
  localparam int VA_W = (3 * MAX_TRIANGLES > 1) ? $clog2(3 * MAX_TRIANGLES) : 1;
  localparam int VC_W = $clog2(3 * MAX_TRIANGLES + 1);
  localparam int SW   = (TC_W > 8) ? TC_W : 8;

  run_state_t state, state_next;

  logic [TC_W-1:0]     rtri, ctri, matched;
  logic [1:0]          rph, cph;
  logic                err;
  logic [TC_W-1:0]     idx_i, idx_j, best;
  logic [VC_W-1:0]     rbase, cbase, bbase;
  logic [1:0]          lane;
  logic [TDIST_W-1:0]  sum, best_d;
  logic [VERTEX_W-1:0] tmp;
  logic [1:0]          run_status;
  logic                p_valid;
  logic [1:0]          p_status;
  logic [TC_W-1:0]     p_count;

  logic                accept, o_free, run_bad;
  logic [VC_W-1:0]     ref_load_addr, cand_load_addr;
  logic [VERTEX_W-1:0] packed_vertex;
  logic [SW-1:0]       slot_ext;

  logic                ref_we, ref_re, cand_we, cand_re;
  logic [VA_W-1:0]     ref_waddr, ref_raddr, cand_waddr, cand_raddr;
  logic [VERTEX_W-1:0] ref_wdata, cand_wdata, ref_rdata, cand_rdata;
  logic                org_we, org_re, dist_we, dist_re;
  logic [TI_W-1:0]     org_waddr, org_raddr, dist_waddr, dist_raddr;
  logic [TI_W-1:0]     org_wdata, org_rdata;
  logic [TDIST_W-1:0]  dist_wdata, dist_rdata;
  logic                vd_start, vd_done;
  logic [VDIST_W-1:0]  vd_dist;

  gtm_ram #(.WIDTH(VERTEX_W), .DEPTH(3 * MAX_TRIANGLES)) u_ref_ram (
    .clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
    .re(ref_re), .raddr(ref_raddr), .rdata(ref_rdata)
  );

  gtm_ram #(.WIDTH(VERTEX_W), .DEPTH(3 * MAX_TRIANGLES)) u_cand_ram (
    .clk(clk), .we(cand_we), .waddr(cand_waddr), .wdata(cand_wdata),
    .re(cand_re), .raddr(cand_raddr), .rdata(cand_rdata)
  );

  gtm_ram #(.WIDTH(TI_W), .DEPTH(MAX_TRIANGLES)) u_org_ram (
    .clk(clk), .we(org_we), .waddr(org_waddr), .wdata(org_wdata),
    .re(org_re), .raddr(org_raddr), .rdata(org_rdata)
  );

  gtm_ram #(.WIDTH(TDIST_W), .DEPTH(MAX_TRIANGLES)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(dist_re), .raddr(dist_raddr), .rdata(dist_rdata)
  );

  gtm_vdist u_vdist (
    .clk(clk), .rst(rst), .start(vd_start),
    .vert_a(ref_rdata), .vert_b(cand_rdata),
    .done(vd_done), .root(vd_dist)
  );

  assign o_free    = !rsp_valid || rsp_ready;
  assign req_ready = (state == RS_IDLE) && (!p_valid || o_free);
  assign accept    = req_valid && req_ready;
  assign run_bad   = (rph != 2'd0) || (cph != 2'd0) || (rtri > ctri);
  assign slot_ext  = SW'(req.slot);
  assign packed_vertex = {req.coord_w, req.coord_z, req.coord_y, req.coord_x};
  assign ref_load_addr  = VC_W'({rtri, 1'b0}) + VC_W'(rtri) + VC_W'(rph);
  assign cand_load_addr = VC_W'({ctri, 1'b0}) + VC_W'(ctri) + VC_W'(cph);

  always_comb begin
    state_next = state;
    unique case (state)
      RS_IDLE: begin
        if (accept && req.kind == KIND_RUN) begin
          state_next = (run_bad || rtri == '0) ? RS_DONE : RS_SCAN_START;
        end
      end
      RS_SCAN_START: state_next = RS_SCAN_RD;
      RS_SCAN_RD:    state_next = RS_SCAN_WAIT;
      RS_SCAN_WAIT:  state_next = RS_SCAN_DIST;
      RS_SCAN_DIST: begin
        if (vd_done) begin
          state_next = (lane == 2'd2) ? RS_SCAN_NEXT : RS_SCAN_RD;
        end
      end
      RS_SCAN_NEXT: begin
        state_next = ((idx_j + TC_W'(1)) < ctri) ? RS_SCAN_RD : RS_SWAP_A;
      end
      RS_SWAP_A: state_next = RS_SWAP_B;
      RS_SWAP_B: state_next = RS_SWAP_C;
      RS_SWAP_C: state_next = RS_SWAP_D;
      RS_SWAP_D: begin
        if (lane == 2'd3) begin
          state_next = ((idx_i + TC_W'(1)) == rtri) ? RS_DONE : RS_SCAN_START;
        end else begin
          state_next = RS_SWAP_A;
        end
      end
      RS_DONE: if (o_free) state_next = RS_IDLE;
      default: state_next = RS_IDLE;
    endcase
  end

  always_comb begin
    ref_we     = 1'b0;
    ref_waddr  = VA_W'(ref_load_addr);
    ref_wdata  = packed_vertex;
    ref_re     = 1'b0;
    ref_raddr  = VA_W'(rbase + VC_W'(lane));
    cand_we    = 1'b0;
    cand_waddr = VA_W'(cand_load_addr);
    cand_wdata = packed_vertex;
    cand_re    = 1'b0;
    cand_raddr = VA_W'(cbase + VC_W'(lane));
    org_we     = 1'b0;
    org_waddr  = TI_W'(ctri);
    org_wdata  = TI_W'(ctri);
    org_re     = 1'b0;
    org_raddr  = TI_W'(req.slot);
    dist_we    = 1'b0;
    dist_waddr = TI_W'(idx_i);
    dist_wdata = best_d;
    dist_re    = 1'b0;
    dist_raddr = TI_W'(req.slot);
    vd_start   = 1'b0;
    unique case (state)
      RS_IDLE: begin
        if (accept) begin
          priority if (req.kind == KIND_LOAD_REF) begin
            ref_we = (rtri != TC_W'(MAX_TRIANGLES));
          end else if (req.kind == KIND_LOAD_CAND) begin
            cand_we = (ctri != TC_W'(MAX_TRIANGLES));
            org_we  = (ctri != TC_W'(MAX_TRIANGLES)) && (cph == 2'd0);
          end else if (req.kind == KIND_READ) begin
            org_re  = 1'b1;
            dist_re = 1'b1;
          end
        end
      end
      RS_SCAN_RD: begin
        ref_re  = 1'b1;
        cand_re = 1'b1;
      end
      RS_SCAN_WAIT: vd_start = 1'b1;
      RS_SWAP_A: begin
        cand_raddr = VA_W'(rbase + VC_W'(lane));
        org_raddr  = TI_W'(idx_i);
        cand_re    = (lane != 2'd3);
        org_re     = (lane == 2'd3);
      end
      RS_SWAP_B: begin
        cand_raddr = VA_W'(bbase + VC_W'(lane));
        org_raddr  = TI_W'(best);
        cand_re    = (lane != 2'd3);
        org_re     = (lane == 2'd3);
      end
      RS_SWAP_C: begin
        cand_waddr = VA_W'(rbase + VC_W'(lane));
        cand_wdata = cand_rdata;
        org_waddr  = TI_W'(idx_i);
        org_wdata  = org_rdata;
        cand_we    = (lane != 2'd3);
        org_we     = (lane == 2'd3);
        dist_we    = (lane == 2'd3);
      end
      RS_SWAP_D: begin
        cand_waddr = VA_W'(bbase + VC_W'(lane));
        cand_wdata = tmp;
        org_waddr  = TI_W'(best);
        org_wdata  = tmp[TI_W-1:0];
        cand_we    = (lane != 2'd3);
        org_we     = (lane == 2'd3);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RS_IDLE;
      rtri      <= '0;
      ctri      <= '0;
      rph       <= '0;
      cph       <= '0;
      err       <= 1'b0;
      matched   <= '0;
      p_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (req.kind)
          KIND_LOAD_REF: begin
            matched <= '0;
            if (rtri == TC_W'(MAX_TRIANGLES)) begin
              err <= 1'b1;
            end else if (rph == 2'd2) begin
              rph  <= '0;
              rtri <= rtri + TC_W'(1);
            end else begin
              rph <= rph + 2'd1;
            end
          end
          KIND_LOAD_CAND: begin
            matched <= '0;
            if (ctri == TC_W'(MAX_TRIANGLES)) begin
              err <= 1'b1;
            end else if (cph == 2'd2) begin
              cph  <= '0;
              ctri <= ctri + TC_W'(1);
            end else begin
              cph <= cph + 2'd1;
            end
          end
          KIND_RUN: matched <= run_bad ? '0 : rtri;
          KIND_CLEAR: begin
            rtri    <= '0;
            ctri    <= '0;
            rph     <= '0;
            cph     <= '0;
            err     <= 1'b0;
            matched <= '0;
          end
          default: begin
          end
        endcase
      end
      if (accept && req.kind == KIND_READ) begin
        p_valid <= 1'b1;
      end else if (p_valid && o_free) begin
        p_valid <= 1'b0;
      end
      if (o_free) begin
        rsp_valid <= p_valid || (state == RS_DONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.kind == KIND_RUN) begin
      run_status <= (run_bad || err) ? STAT_ERROR : STAT_OK;
      idx_i      <= '0;
      rbase      <= '0;
    end
    if (accept && req.kind == KIND_READ) begin
      p_status <= (slot_ext >= SW'(matched) || slot_ext >= SW'(MAX_TRIANGLES))
                  ? STAT_SLOT : STAT_OK;
      p_count  <= matched;
    end
    if (o_free) begin
      if (p_valid) begin
        rsp.status          <= p_status;
        rsp.source_triangle <= (p_status == STAT_OK) ? 8'(org_rdata) : 8'd0;
        rsp.match_distance  <= (p_status == STAT_OK) ? dist_rdata : '0;
        rsp.triangle_count  <= 9'(p_count);
      end else if (state == RS_DONE) begin
        rsp.status          <= run_status;
        rsp.source_triangle <= 8'd0;
        rsp.match_distance  <= '0;
        rsp.triangle_count  <= 9'(matched);
      end
    end
    unique case (state)
      RS_SCAN_START: begin
        idx_j <= idx_i;
        cbase <= rbase;
        lane  <= '0;
        sum   <= '0;
      end
      RS_SCAN_DIST: begin
        if (vd_done) begin
          sum <= sum + TDIST_W'(vd_dist);
          if (lane != 2'd2) begin
            lane <= lane + 2'd1;
          end
        end
      end
      RS_SCAN_NEXT: begin
        if (idx_j == idx_i || sum < best_d) begin
          best   <= idx_j;
          bbase  <= cbase;
          best_d <= sum;
        end
        lane <= '0;
        if ((idx_j + TC_W'(1)) < ctri) begin
          idx_j <= idx_j + TC_W'(1);
          cbase <= cbase + VC_W'(3);
          sum   <= '0;
        end
      end
      RS_SWAP_B: tmp <= (lane == 2'd3) ? VERTEX_W'(org_rdata) : cand_rdata;
      RS_SWAP_D: begin
        if (lane == 2'd3) begin
          idx_i <= idx_i + TC_W'(1);
          rbase <= rbase + VC_W'(3);
          lane  <= '0;
        end else begin
          lane <= lane + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state != RS_IDLE |-> !p_valid)
    else $error("read beat pending during a run");

  a_vd_owner: assert property (@(posedge clk) disable iff (rst)
    vd_done |-> state == RS_SCAN_DIST)
    else $error("distance unit finished outside the scan");

  a_ref_bound: assert property (@(posedge clk) disable iff (rst)
    (state == RS_SCAN_RD || state == RS_SWAP_A) |-> idx_i < rtri)
    else $error("reference index beyond loaded triangles");

  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    state == RS_SCAN_RD |-> (idx_j < ctri && lane != 2'd3))
    else $error("candidate scan out of range");
`endif

endmodule
